@@ src/pee_pkg.sv @@
// shared constants and propeller tables for the propeller efficiency estimator
// no dependencies; imported by propeller_efficiency_estimator and its testbench
package pee_pkg;

  localparam int PEE_TABLE_A_POINTS = 29;
  localparam int PEE_TABLE_B_POINTS = 27;
  localparam int PEE_SLOTS          = 64;

  localparam int XW = 18;  // table J, Q2.16
  localparam int YW = 20;  // table Kq, signed Q0.20 (20 bits incl. sign)

  localparam logic [5:0]  J_MUL   = 6'd36;   // 36 * 2^16 = 2359296
  localparam logic [3:0]  J_DEN   = 4'd13;
  localparam logic [29:0] EFF_DIV = 30'd799964774;

  localparam logic [17:0] Q16_MAX = 18'h3ffff;
  localparam logic [19:0] KQ_MAX  = 20'h7ffff;
  localparam logic [19:0] KQ_MIN  = 20'h80000;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RPM_ZERO  = 2'd1;
  localparam logic [1:0] ST_PWR_ZERO  = 2'd2;

  // entry = {J, Kq}; slots past the given points read as zero
  function automatic logic [XW+YW-1:0] tab_a(input logic [5:0] idx);
    logic [XW+YW-1:0] r;
    case (idx)
      6'd0:  r = {18'd75380, 20'd930};
      6'd1:  r = {18'd75214, 20'd1036};
      6'd2:  r = {18'd75049, 20'd1142};
      6'd3:  r = {18'd74883, 20'd1247};
      6'd4:  r = {18'd74718, 20'd1352};
      6'd5:  r = {18'd74552, 20'd1449};
      6'd6:  r = {18'd71275, 20'd3486};
      6'd7:  r = {18'd67998, 20'd5357};
      6'd8:  r = {18'd64722, 20'd7114};
      6'd9:  r = {18'd61445, 20'd8732};
      6'd10: r = {18'd58168, 20'd10204};
      6'd11: r = {18'd54891, 20'd11535};
      6'd12: r = {18'd51614, 20'd12732};
      6'd13: r = {18'd48338, 20'd13792};
      6'd14: r = {18'd45061, 20'd14718};
      6'd15: r = {18'd41784, 20'd15512};
      6'd16: r = {18'd38507, 20'd16167};
      6'd17: r = {18'd35230, 20'd16676};
      6'd18: r = {18'd31954, 20'd17050};
      6'd19: r = {18'd28677, 20'd17321};
      6'd20: r = {18'd25400, 20'd17534};
      6'd21: r = {18'd22123, 20'd17706};
      6'd22: r = {18'd18846, 20'd17858};
      6'd23: r = {18'd15570, 20'd18075};
      6'd24: r = {18'd12293, 20'd18212};
      6'd25: r = {18'd9016,  20'd18411};
      6'd26: r = {18'd5739,  20'd18650};
      6'd27: r = {18'd2462,  20'd18857};
      6'd28: r = {18'd1807,  20'd18904};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [XW+YW-1:0] tab_b(input logic [5:0] idx);
    logic [XW+YW-1:0] r;
    case (idx)
      6'd0:  r = {18'd95253, 20'd2347};
      6'd1:  r = {18'd95137, 20'd2460};
      6'd2:  r = {18'd95021, 20'd2573};
      6'd3:  r = {18'd94905, 20'd2687};
      6'd4:  r = {18'd94789, 20'd2799};
      6'd5:  r = {18'd94673, 20'd2902};
      6'd6:  r = {18'd94024, 20'd3538};
      6'd7:  r = {18'd93374, 20'd4165};
      6'd8:  r = {18'd92724, 20'd4788};
      6'd9:  r = {18'd92074, 20'd5435};
      6'd10: r = {18'd88798, 20'd8487};
      6'd11: r = {18'd85521, 20'd11403};
      6'd12: r = {18'd82244, 20'd14129};
      6'd13: r = {18'd78967, 20'd16739};
      6'd14: r = {18'd75690, 20'd19190};
      6'd15: r = {18'd72414, 20'd21480};
      6'd16: r = {18'd69137, 20'd23600};
      6'd17: r = {18'd65860, 20'd25565};
      6'd18: r = {18'd62583, 20'd27366};
      6'd19: r = {18'd59306, 20'd29017};
      6'd20: r = {18'd56030, 20'd30515};
      6'd21: r = {18'd52753, 20'd31850};
      6'd22: r = {18'd49476, 20'd33055};
      6'd23: r = {18'd46199, 20'd34090};
      6'd24: r = {18'd42922, 20'd34947};
      6'd25: r = {18'd42267, 20'd35087};
      6'd26: r = {18'd41612, 20'd35233};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/propeller_efficiency_estimator.sv @@
// Propeller efficiency estimator: one result per input transfer, handled one item at a time.
// Each item runs up to three passes of a shared restoring divider (J, interpolated Kq,
// efficiency; a pass ends early when the quotient overflows) and a linear scan of the
// selected J table, one entry per cycle through its registered read port. With rpm zero
// the item goes straight to the output stage, with no divider pass and no table scan.
// A new item is taken once the previous result is loaded into the output register.
// Depends on pee_pkg.
module propeller_efficiency_estimator #(
  parameter int TABLE_A_POINTS = pee_pkg::PEE_TABLE_A_POINTS,
  parameter int TABLE_B_POINTS = pee_pkg::PEE_TABLE_B_POINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // motor_power[15:0], motor_rpm[29:16], water_speed[43:30], zero
  input  logic [0:0]  in_tuser,   // prop_select[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // efficiency[17:0], advance_ratio[35:18], torque_coeff[55:36]
  output logic [1:0]  out_tuser   // result_status[1:0]
);
  import pee_pkg::*;

  localparam int LEN_A = (TABLE_A_POINTS < 2) ? 2 :
                         ((TABLE_A_POINTS > PEE_SLOTS) ? PEE_SLOTS : TABLE_A_POINTS);
  localparam int LEN_B = (TABLE_B_POINTS < 2) ? 2 :
                         ((TABLE_B_POINTS > PEE_SLOTS) ? PEE_SLOTS : TABLE_B_POINTS);
  localparam logic [6:0] LENM2_A = 7'(LEN_A - 2);
  localparam logic [6:0] LENM2_B = 7'(LEN_B - 2);

  localparam int NW = 62;  // dividend width
  localparam int DW = 46;  // divisor width
  localparam int QW = 21;  // quotient bits before overflow
  localparam logic [4:0] QTOP = 5'(QW);

  typedef enum logic [4:0] {
    S_IDLE, S_JDIV, S_JFIN, S_SCAN, S_RD0, S_RD1, S_RD2, S_INTP, S_KLD, S_KDIV,
    S_KFIN, S_P2, S_P3, S_A0, S_A1, S_EDIV, S_EFIN, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] pwr_r;
  logic [13:0] rpm_r;
  logic [13:0] ws_r;
  logic        sel_r;

  logic [XW+YW-1:0] rom_q_r;
  logic [5:0]       rom_addr;

  logic [6:0]  scan_k_r;
  logic [6:0]  pend_k_r;
  logic        pend_r;
  logic [5:0]  seg_r;

  logic [17:0] x0_r, x1_r, kden_r;
  logic [19:0] y0_r, y1_r;
  logic signed [39:0] prod_r;
  logic        neg_r;

  logic [NW-1:0]    div_rem_r;
  logic [DW+QW-1:0] div_dsh_r;
  logic [QW-1:0]    div_q_r;
  logic             div_ovf_r;
  logic [4:0]       div_i_r;
  logic             div_ge;
  logic             div_done;

  logic [17:0] j_r;
  logic [19:0] kq_r;
  logic [17:0] eff_r;
  logic [1:0]  stat_r;
  logic [27:0] p2_r;
  logic [41:0] p3_r;
  logic [NW-1:0] a_r;
  logic [DW-1:0] eden_r;

  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  logic [6:0]  lenm2;
  logic        issue;
  logic signed [20:0] dy;
  logic signed [18:0] dx;
  logic signed [39:0] prod;
  logic [39:0] mag;
  logic signed [23:0] qs;
  logic signed [23:0] ksum;
  logic [19:0] kq_fin;
  logic [18:0] kq19;
  logic        kq_pos;
  logic [39:0] alo, ahi;
  logic [17:0] q_sat;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign lenm2  = sel_r ? LENM2_B : LENM2_A;
  assign issue  = (scan_k_r <= lenm2);
  assign div_ge = ({{(DW+QW-NW){1'b0}}, div_rem_r} >= div_dsh_r);
  assign div_done = (div_ge && div_i_r == QTOP) || (div_i_r == 5'd0);

  always_comb begin
    unique case (state_r)
      S_SCAN:  rom_addr = scan_k_r[5:0];
      S_RD1:   rom_addr = seg_r + 6'd1;
      default: rom_addr = seg_r;
    endcase
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    rom_q_r <= sel_r ? tab_b(rom_addr) : tab_a(rom_addr);
  end

  always_comb begin
    dy   = $signed({y1_r[19], y1_r}) - $signed({y0_r[19], y0_r});
    dx   = $signed({1'b0, x0_r}) - $signed({1'b0, j_r});
    prod = dy * dx;
    mag  = prod_r[39] ? 40'(-prod_r) : 40'(prod_r);
    // floor division: round magnitude up when negative with a remainder
    qs   = $signed({3'b000, div_q_r}) + ((neg_r && div_rem_r != '0) ? 24'sd1 : 24'sd0);
    if (neg_r) qs = -qs;
    ksum = $signed({{4{y0_r[19]}}, y0_r}) + qs;
    if (div_ovf_r)
      kq_fin = neg_r ? KQ_MIN : KQ_MAX;
    else if (ksum > 24'sd524287)
      kq_fin = KQ_MAX;
    else if (ksum < -24'sd524288)
      kq_fin = KQ_MIN;
    else
      kq_fin = ksum[19:0];
    kq19   = kq_r[18:0];
    kq_pos = !kq_r[19] && (kq_r != '0);
    alo    = p3_r[20:0] * kq19;
    ahi    = p3_r[41:21] * kq19;
    q_sat  = (div_ovf_r || div_q_r > {3'b000, Q16_MAX}) ? Q16_MAX : div_q_r[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;

      if (state_r == S_JDIV || state_r == S_KDIV || state_r == S_EDIV) begin
        if (div_ge && div_i_r == QTOP)
          div_ovf_r <= 1'b1;
        else if (div_ge)
          div_rem_r <= div_rem_r - div_dsh_r[NW-1:0];
        div_q_r   <= {div_q_r[QW-2:0], div_ge};
        div_dsh_r <= div_dsh_r >> 1;
        div_i_r   <= div_i_r - 5'd1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pwr_r <= in_tdata[15:0];
            rpm_r <= in_tdata[29:16];
            ws_r  <= in_tdata[43:30];
            sel_r <= in_tuser[0];
            if (in_tdata[29:16] == '0) begin
              eff_r   <= '0;
              j_r     <= '0;
              kq_r    <= '0;
              stat_r  <= ST_RPM_ZERO;
              state_r <= S_DONE;
            end else begin
              stat_r    <= (in_tdata[15:0] == '0) ? ST_PWR_ZERO : ST_OK;
              div_rem_r <= NW'({20'(in_tdata[43:30]) * 20'(J_MUL), 16'h0000});
              div_dsh_r <= {DW'(in_tdata[29:16]) * DW'(J_DEN), {QW{1'b0}}};
              div_q_r   <= '0;
              div_ovf_r <= 1'b0;
              div_i_r   <= QTOP;
              state_r   <= S_JDIV;
            end
          end
        end
        S_JDIV: if (div_done) state_r <= S_JFIN;
        S_JFIN: begin
          j_r      <= q_sat;
          seg_r    <= '0;
          scan_k_r <= 7'd1;
          pend_r   <= 1'b0;
          state_r  <= S_SCAN;
        end
        S_SCAN: begin
          // last segment whose left J is at or above the input J
          if (pend_r && rom_q_r[XW+YW-1:YW] >= j_r) seg_r <= pend_k_r[5:0];
          pend_r   <= issue;
          pend_k_r <= scan_k_r;
          if (issue) scan_k_r <= scan_k_r + 7'd1;
          if (!issue && !pend_r) state_r <= S_RD0;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          x0_r    <= rom_q_r[XW+YW-1:YW];
          y0_r    <= rom_q_r[YW-1:0];
          state_r <= S_RD2;
        end
        S_RD2: begin
          x1_r    <= rom_q_r[XW+YW-1:YW];
          y1_r    <= rom_q_r[YW-1:0];
          state_r <= S_INTP;
        end
        S_INTP: begin
          if (x0_r <= x1_r) begin
            kq_r    <= y0_r;
            state_r <= S_P2;
          end else begin
            prod_r  <= prod;
            kden_r  <= x0_r - x1_r;
            state_r <= S_KLD;
          end
        end
        S_KLD: begin
          neg_r     <= prod_r[39];
          div_rem_r <= NW'(mag);
          div_dsh_r <= {DW'(kden_r), {QW{1'b0}}};
          div_q_r   <= '0;
          div_ovf_r <= 1'b0;
          div_i_r   <= QTOP;
          state_r   <= S_KDIV;
        end
        S_KDIV: if (div_done) state_r <= S_KFIN;
        S_KFIN: begin
          kq_r    <= kq_fin;
          state_r <= S_P2;
        end
        S_P2: begin
          p2_r    <= rpm_r * rpm_r;
          state_r <= S_P3;
        end
        S_P3: begin
          p3_r    <= p2_r * rpm_r;
          state_r <= S_A0;
        end
        S_A0: begin
          a_r     <= NW'(alo);
          eden_r  <= pwr_r * EFF_DIV;
          state_r <= S_A1;
        end
        S_A1: begin
          if (pwr_r == '0 || !kq_pos) begin
            eff_r   <= '0;
            state_r <= S_DONE;
          end else begin
            div_rem_r <= a_r + NW'({ahi, 21'h0});
            div_dsh_r <= {eden_r, {QW{1'b0}}};
            div_q_r   <= '0;
            div_ovf_r <= 1'b0;
            div_i_r   <= QTOP;
            state_r   <= S_EDIV;
          end
        end
        S_EDIV: if (div_done) state_r <= S_EFIN;
        S_EFIN: begin
          eff_r   <= q_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {kq_r, j_r, eff_r};
            out_tuser_r  <= stat_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sim/propeller_efficiency_estimator_tb.sv @@
// testbench for propeller_efficiency_estimator: directed and random items, results
// checked against an in-bench efficiency predictor; depends on pee_pkg and the block
module propeller_efficiency_estimator_tb;
  import pee_pkg::*;

  typedef struct packed {
    logic [19:0] kq;
    logic [17:0] jadv;
    logic [17:0] eff;
    logic [1:0]  status;
  } eff_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  eff_result_t expected_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  bit          hold_off = 1'b0;
  bit          timed_out = 1'b0;

  always #5 clk = ~clk;

  propeller_efficiency_estimator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic eff_result_t predict_efficiency(logic [15:0] pwr, logic [13:0] rpm,
                                                     logic [13:0] ws, logic sel);
    eff_result_t r;
    longint unsigned j, a, e;
    longint x0, x1, y0, y1, num, den, kq, entry0, entry1;
    int seg, len;
    r = '0;
    if (rpm == 0) begin
      r.status = ST_RPM_ZERO;
      return r;
    end
    j = (64'(ws) * 36 * 65536) / (64'(J_DEN) * rpm);
    if (j > Q16_MAX) j = Q16_MAX;
    len = sel ? PEE_TABLE_B_POINTS : PEE_TABLE_A_POINTS;
    seg = 0;
    for (int k = 1; k <= len - 2; k++) begin
      entry0 = sel ? tab_b(6'(k)) >> YW : tab_a(6'(k)) >> YW;
      if (entry0 >= longint'(j)) seg = k;
    end
    entry0 = sel ? tab_b(6'(seg)) : tab_a(6'(seg));
    entry1 = sel ? tab_b(6'(seg + 1)) : tab_a(6'(seg + 1));
    x0 = entry0 >> YW;
    x1 = entry1 >> YW;
    y0 = entry0 & 64'hfffff;
    y1 = entry1 & 64'hfffff;
    den = x0 - x1;
    if (den <= 0) kq = y0;
    else begin
      num = (y1 - y0) * (x0 - longint'(j));
      kq = y0 + ((num >= 0) ? num / den : -((-num + den - 1) / den));
      if (kq > 524287) kq = 524287;
      if (kq < -524288) kq = -524288;
    end
    e = 0;
    if (pwr != 0 && kq > 0) begin
      a = 64'(rpm) * rpm * rpm * longint'(kq);
      e = a / (64'(pwr) * EFF_DIV);
      if (e > Q16_MAX) e = Q16_MAX;
    end
    r.eff = 18'(e);
    r.jadv = 18'(j);
    r.kq = 20'(kq);
    r.status = (pwr == 0) ? ST_PWR_ZERO : ST_OK;
    return r;
  endfunction

  task automatic send_item(logic [15:0] pwr, logic [13:0] rpm, logic [13:0] ws, logic sel);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, ws, rpm, pwr};
    in_tuser <= sel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_efficiency(pwr, rpm, ws, sel));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  // receiver side: random stall bursts, or a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (receiver_idles && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    eff_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: eff %0d/%0d J %0d/%0d kq %0d/%0d status %0d/%0d (exp/act)",
                     want.eff, got.eff, want.jadv, got.jadv, $signed(want.kq),
                     $signed(got.kq), want.status, got.status);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(16'd1000, 14'd0, 14'd3000, 1'b0);      // rpm zero
    send_item(16'd0, 14'd0, 14'd3000, 1'b1);         // rpm zero wins over power zero
    send_item(16'd0, 14'd3000, 14'd2000, 1'b0);      // power zero
    send_item(16'd65535, 14'd16383, 14'd16383, 1'b0);
    send_item(16'd65535, 14'd16383, 14'd16383, 1'b1);
    send_item(16'd1, 14'd16383, 14'd0, 1'b0);        // J zero, extrapolate past end
    send_item(16'd1, 14'd16383, 14'd0, 1'b1);
    send_item(16'd1, 14'd1, 14'd16383, 1'b0);        // J saturates, negative kq
    send_item(16'd1, 14'd1, 14'd16383, 1'b1);
    send_item(16'd1, 14'd16383, 14'd1000, 1'b0);     // efficiency saturates
    send_item(16'd500, 14'd2000, 14'd3000, 1'b0);
    send_item(16'd500, 14'd2000, 14'd4000, 1'b1);
    send_item(16'd800, 14'd3600, 14'd5000, 1'b0);
    send_item(16'd800, 14'd3600, 14'd7500, 1'b1);
    send_item(16'd32768, 14'd8192, 14'd8192, 1'b0);
    send_item(16'd1, 14'd1, 14'd1, 1'b1);
  endtask

  // items with J mostly inside the table ranges, some across the whole field space
  task automatic test_random(int count);
    logic [13:0] rpm, ws;
    logic sel;
    for (int i = 0; i < count; i++) begin
      sel = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        rpm = 14'($urandom());
        ws = 14'($urandom());
        send_item(16'($urandom()), rpm, ws, sel);
      end else begin
        rpm = 14'($urandom_range(200, 16383));
        // J = ws*2359296/(13*rpm); aim for J up to about 1.5 in Q2.16
        ws = 14'((longint'(rpm) * $urandom_range(0, 100000) * 13) / 2359296);
        send_item(16'($urandom_range(1, 65535)), rpm, ws, sel);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(6);
    join
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1700);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(300);
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
